[hw/rtl/tcd_pkg.sv]
`timescale 1ns / 1ps

package tcd_pkg;

    // color kinds
    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_INDEX   = 2'd1;
    localparam logic [1:0] KIND_RGB     = 2'd2;

    // terminal color modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_BASIC = 2'd1;
    localparam logic [1:0] MODE_256   = 2'd2;
    localparam logic [1:0] MODE_TRUE  = 2'd3;

    // configuration map
    localparam int         CFG_ADDR_W         = 3;
    localparam logic       REG_IDX_COLOR_MODE = 1'b0;
    localparam logic [1:0] COLOR_MODE_RESET   = MODE_TRUE;

    localparam int DIST_W     = 18;
    localparam int NUM_BASIC  = 16;
    localparam int BASIC_IDXW = 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] kind;
        logic [7:0] index;
        t_rgb       rgb;
    } t_item;

    function automatic t_rgb mk_rgb(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        t_rgb c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    function automatic t_rgb basic_rgb(input logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = mk_rgb(8'd0,   8'd0,   8'd0);
            4'd1:    c = mk_rgb(8'd205, 8'd0,   8'd0);
            4'd2:    c = mk_rgb(8'd0,   8'd205, 8'd0);
            4'd3:    c = mk_rgb(8'd205, 8'd205, 8'd0);
            4'd4:    c = mk_rgb(8'd0,   8'd0,   8'd238);
            4'd5:    c = mk_rgb(8'd205, 8'd0,   8'd205);
            4'd6:    c = mk_rgb(8'd0,   8'd205, 8'd205);
            4'd7:    c = mk_rgb(8'd229, 8'd229, 8'd229);
            4'd8:    c = mk_rgb(8'd127, 8'd127, 8'd127);
            4'd9:    c = mk_rgb(8'd255, 8'd0,   8'd0);
            4'd10:   c = mk_rgb(8'd0,   8'd255, 8'd0);
            4'd11:   c = mk_rgb(8'd255, 8'd255, 8'd0);
            4'd12:   c = mk_rgb(8'd92,  8'd92,  8'd255);
            4'd13:   c = mk_rgb(8'd255, 8'd0,   8'd255);
            4'd14:   c = mk_rgb(8'd0,   8'd255, 8'd255);
            default: c = mk_rgb(8'd255, 8'd255, 8'd255);
        endcase
        return c;
    endfunction

    // cube level (0..5) to channel value
    function automatic logic [7:0] cube_value(input logic [2:0] lvl);
        logic [7:0] v;
        case (lvl)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd95;
            3'd2:    v = 8'd135;
            3'd3:    v = 8'd175;
            3'd4:    v = 8'd215;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // channel value to nearest cube level
    function automatic logic [2:0] chan_level(input logic [7:0] c);
        logic [2:0] l;
        if (c < 8'd48)       l = 3'd0;
        else if (c < 8'd115) l = 3'd1;
        else if (c < 8'd155) l = 3'd2;
        else if (c < 8'd195) l = 3'd3;
        else if (c < 8'd235) l = 3'd4;
        else                 l = 3'd5;
        return l;
    endfunction

    // base-6 high digit of 0..35 (the value divided by 6) by compares
    function automatic logic [2:0] div6(input logic [5:0] v);
        logic [2:0] q;
        q = 3'(v >= 6'd6) + 3'(v >= 6'd12) + 3'(v >= 6'd18)
          + 3'(v >= 6'd24) + 3'(v >= 6'd30);
        return q;
    endfunction

    // full palette index to its RGB value
    function automatic t_rgb palette_rgb(input logic [7:0] idx);
        t_rgb       c;
        logic [7:0] off;
        logic [2:0] lr;
        logic [2:0] lg;
        logic [5:0] rem;
        logic [5:0] rem6;
        logic [4:0] gs;
        logic [7:0] gv;
        off  = idx - 8'd16;
        lr   = 3'(off >= 8'd36) + 3'(off >= 8'd72) + 3'(off >= 8'd108)
             + 3'(off >= 8'd144) + 3'(off >= 8'd180);
        rem  = 6'(off - 8'd36 * {5'd0, lr});
        lg   = div6(rem);
        rem6 = rem - 6'({lg, 2'b0} + {1'b0, lg, 1'b0});
        gs   = 5'(idx - 8'd232);
        gv   = 8'd8 + {gs, 3'b0} + {2'b0, gs, 1'b0};
        if (idx < 8'd16) begin
            c = basic_rgb(idx[3:0]);
        end else if (idx < 8'd232) begin
            c = mk_rgb(cube_value(lr), cube_value(lg), cube_value(rem6[2:0]));
        end else begin
            c = mk_rgb(gv, gv, gv);
        end
        return c;
    endfunction

    function automatic logic [DIST_W-1:0] sq_dist(input t_rgb a, input t_rgb b);
        logic [7:0]  dr;
        logic [7:0]  dg;
        logic [7:0]  db;
        logic [15:0] sr;
        logic [15:0] sg;
        logic [15:0] sb;
        dr = (a.red   >= b.red)   ? a.red   - b.red   : b.red   - a.red;
        dg = (a.green >= b.green) ? a.green - b.green : b.green - a.green;
        db = (a.blue  >= b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;
        sr = 16'(dr) * 16'(dr);
        sg = 16'(dg) * 16'(dg);
        sb = 16'(db) * 16'(db);
        return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    endfunction

endpackage

[hw/rtl/terminal_color_degrader_core.sv]
`timescale 1ns / 1ps

// Terminal color degrader: reduces one color per beat to what the terminal
// mode in color_mode can show (none, basic 16, 256 palette, truecolor).
// Input channel: i_valid / o_stall with kind, palette index and RGB fields.
// Output channel: o_valid / i_stall with the degraded color; fields that
// the result kind does not use are zero.
// Throughput: one beat per cycle, sustained, as long as the output is not
// stalled. Pipeline: an accepted beat passes the input register, stages 2
// to 4 and the output register; the depth is set by the path of the basic
// mode, which squares the distance to all 16 basic colors and then picks
// the nearest through a two-stage registered minimum tree.
// Stall: while the output holds a beat and i_stall is high, the whole
// pipeline freezes and o_stall is raised; nothing is dropped.
// Reset: synchronous, active low; empties the pipeline and sets color_mode
// to truecolor. color_mode is written through the APB port at addresses 0
// to 3 (paddr[2] low) and must only change while no beat is in flight.
module terminal_color_degrader_core
    import tcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_color_kind,
    input  logic [7:0]            i_color_index,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_out_kind,
    output logic [7:0]            o_out_index,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [1:0] r_color_mode;
    logic       w_adv;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_COLOR_MODE) ? {30'd0, r_color_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= COLOR_MODE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_IDX_COLOR_MODE) begin
            r_color_mode <= pwdata[1:0];
        end
    end

    // whole pipe advances unless the output beat is held
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // ---------------- stage 1: input register ----------------
    logic  r1_valid;
    t_item r1_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_valid;
        end
        if (w_adv) begin
            r1_item.mode  <= r_color_mode;
            r1_item.kind  <= i_color_kind;
            r1_item.index <= i_color_index;
            r1_item.rgb   <= mk_rgb(i_red, i_green, i_blue);
        end
    end

    // target color, cube levels and channel average
    t_rgb        n_tgt;
    logic [9:0]  n_sum;
    logic [19:0] n_avg_prod;
    logic [2:0]  n_lvl_r;
    logic [2:0]  n_lvl_g;
    logic [2:0]  n_lvl_b;

    always_comb begin
        n_tgt      = (r1_item.kind == KIND_RGB) ? r1_item.rgb : palette_rgb(r1_item.index);
        n_sum      = 10'(r1_item.rgb.red) + 10'(r1_item.rgb.green) + 10'(r1_item.rgb.blue);
        // divide by 3: exact for sums below 2048
        n_avg_prod = 20'(n_sum) * 20'd683;
        n_lvl_r    = chan_level(r1_item.rgb.red);
        n_lvl_g    = chan_level(r1_item.rgb.green);
        n_lvl_b    = chan_level(r1_item.rgb.blue);
    end

    // ---------------- stage 2 ----------------
    logic       r2_valid;
    t_item      r2_item;
    t_rgb       r2_tgt;
    logic [7:0] r2_avg;
    logic [2:0] r2_lvl_r;
    logic [2:0] r2_lvl_g;
    logic [2:0] r2_lvl_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
        if (w_adv) begin
            r2_item  <= r1_item;
            r2_tgt   <= n_tgt;
            r2_avg   <= n_avg_prod[18:11];
            r2_lvl_r <= n_lvl_r;
            r2_lvl_g <= n_lvl_g;
            r2_lvl_b <= n_lvl_b;
        end
    end

    // basic distances, cube and gray candidates
    logic [DIST_W-1:0] n_dist [NUM_BASIC];
    logic [7:0]        n_avg_m8;
    logic [15:0]       n_step_prod;
    logic [4:0]        n_step;
    logic [7:0]        n_gray_v;
    logic [7:0]        n_gray_idx;
    logic [7:0]        n_cube_idx;
    t_rgb              n_cube_rgb;
    t_rgb              n_gray_rgb;

    always_comb begin
        for (int i = 0; i < NUM_BASIC; i++) begin
            n_dist[i] = sq_dist(r2_tgt, basic_rgb(BASIC_IDXW'(i)));
        end
        n_avg_m8    = (r2_avg < 8'd8) ? 8'd0 : r2_avg - 8'd8;
        // divide by 10: exact for every 8-bit value
        n_step_prod = 16'(n_avg_m8) * 16'd205;
        n_step      = (n_step_prod[15:11] > 5'd23) ? 5'd23 : n_step_prod[15:11];
        n_gray_v    = 8'd8 + {n_step, 3'b0} + {2'b0, n_step, 1'b0};
        n_gray_idx  = 8'd232 + {3'd0, n_step};
        n_cube_idx  = 8'd16 + 8'd36 * {5'd0, r2_lvl_r}
                    + 8'd6 * {5'd0, r2_lvl_g} + {5'd0, r2_lvl_b};
        n_cube_rgb  = mk_rgb(cube_value(r2_lvl_r), cube_value(r2_lvl_g),
                             cube_value(r2_lvl_b));
        n_gray_rgb  = mk_rgb(n_gray_v, n_gray_v, n_gray_v);
    end

    // ---------------- stage 3 ----------------
    logic              r3_valid;
    t_item             r3_item;
    logic [DIST_W-1:0] r3_dist [NUM_BASIC];
    logic [7:0]        r3_cube_idx;
    logic [7:0]        r3_gray_idx;
    t_rgb              r3_cube_rgb;
    t_rgb              r3_gray_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
        if (w_adv) begin
            r3_item     <= r2_item;
            r3_dist     <= n_dist;
            r3_cube_idx <= n_cube_idx;
            r3_gray_idx <= n_gray_idx;
            r3_cube_rgb <= n_cube_rgb;
            r3_gray_rgb <= n_gray_rgb;
        end
    end

    // first two levels of the minimum tree; the lower index keeps ties
    logic [DIST_W-1:0]     n_l1_d [8];
    logic [BASIC_IDXW-1:0] n_l1_i [8];
    logic [DIST_W-1:0]     n_l2_d [4];
    logic [BASIC_IDXW-1:0] n_l2_i [4];
    logic [DIST_W-1:0]     n_d_cube;
    logic [DIST_W-1:0]     n_d_gray;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (r3_dist[2*i+1] < r3_dist[2*i]) begin
                n_l1_d[i] = r3_dist[2*i+1];
                n_l1_i[i] = BASIC_IDXW'(2*i+1);
            end else begin
                n_l1_d[i] = r3_dist[2*i];
                n_l1_i[i] = BASIC_IDXW'(2*i);
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (n_l1_d[2*i+1] < n_l1_d[2*i]) begin
                n_l2_d[i] = n_l1_d[2*i+1];
                n_l2_i[i] = n_l1_i[2*i+1];
            end else begin
                n_l2_d[i] = n_l1_d[2*i];
                n_l2_i[i] = n_l1_i[2*i];
            end
        end
        n_d_cube = sq_dist(r3_item.rgb, r3_cube_rgb);
        n_d_gray = sq_dist(r3_item.rgb, r3_gray_rgb);
    end

    // ---------------- stage 4 ----------------
    logic                  r4_valid;
    t_item                 r4_item;
    logic [DIST_W-1:0]     r4_min_d [4];
    logic [BASIC_IDXW-1:0] r4_min_i [4];
    logic [DIST_W-1:0]     r4_d_cube;
    logic [DIST_W-1:0]     r4_d_gray;
    logic [7:0]            r4_cube_idx;
    logic [7:0]            r4_gray_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r4_valid <= r3_valid;
        end
        if (w_adv) begin
            r4_item     <= r3_item;
            r4_min_d    <= n_l2_d;
            r4_min_i    <= n_l2_i;
            r4_d_cube   <= n_d_cube;
            r4_d_gray   <= n_d_gray;
            r4_cube_idx <= r3_cube_idx;
            r4_gray_idx <= r3_gray_idx;
        end
    end

    // last tree levels and result select
    logic [DIST_W-1:0]     n_l3_d [2];
    logic [BASIC_IDXW-1:0] n_l3_i [2];
    logic [BASIC_IDXW-1:0] n_basic;
    logic [7:0]            n_idx256;
    logic [1:0]            n_kind;
    logic [7:0]            n_index;
    t_rgb                  n_rgb;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (r4_min_d[2*i+1] < r4_min_d[2*i]) begin
                n_l3_d[i] = r4_min_d[2*i+1];
                n_l3_i[i] = r4_min_i[2*i+1];
            end else begin
                n_l3_d[i] = r4_min_d[2*i];
                n_l3_i[i] = r4_min_i[2*i];
            end
        end
        n_basic  = (n_l3_d[1] < n_l3_d[0]) ? n_l3_i[1] : n_l3_i[0];
        // cube wins a tie
        n_idx256 = (r4_d_cube <= r4_d_gray) ? r4_cube_idx : r4_gray_idx;

        n_kind  = KIND_DEFAULT;
        n_index = 8'd0;
        n_rgb   = mk_rgb(8'd0, 8'd0, 8'd0);
        if (r4_item.mode != MODE_NONE) begin
            case (r4_item.kind)
                KIND_INDEX: begin
                    n_kind = KIND_INDEX;
                    if (r4_item.mode == MODE_BASIC && r4_item.index >= 8'd16) begin
                        n_index = {4'd0, n_basic};
                    end else begin
                        n_index = r4_item.index;
                    end
                end
                KIND_RGB: begin
                    case (r4_item.mode)
                        MODE_TRUE: begin
                            n_kind = KIND_RGB;
                            n_rgb  = r4_item.rgb;
                        end
                        MODE_256: begin
                            n_kind  = KIND_INDEX;
                            n_index = n_idx256;
                        end
                        default: begin
                            n_kind  = KIND_INDEX;
                            n_index = {4'd0, n_basic};
                        end
                    endcase
                end
                default: begin
                    n_kind = KIND_DEFAULT;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_index;
    t_rgb       r_out_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r4_valid;
        end
        if (w_adv) begin
            r_out_kind  <= n_kind;
            r_out_index <= n_index;
            r_out_rgb   <= n_rgb;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_index = r_out_index;
    assign o_out_red   = r_out_rgb.red;
    assign o_out_green = r_out_rgb.green;
    assign o_out_blue  = r_out_rgb.blue;

    // ---------------- assertions ----------------
    a_rgb_zero_unless_rgb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind != KIND_RGB
        |-> o_out_red == 8'd0 && o_out_green == 8'd0 && o_out_blue == 8'd0)
        else $error("RGB fields nonzero on a non-RGB result");

    a_index_zero_unless_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind != KIND_INDEX |-> o_out_index == 8'd0)
        else $error("index nonzero on a non-index result");

    a_mode_none_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && w_adv && r4_item.mode == MODE_NONE
        |=> o_valid && o_out_kind == KIND_DEFAULT)
        else $error("mode none produced a non-default color");

    a_basic_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && w_adv && r4_item.mode == MODE_BASIC && r4_item.kind == KIND_INDEX
        |=> o_valid && o_out_index[7:4] == 4'd0)
        else $error("basic mode produced an index above 15");

endmodule
